// ===== design/elrl_pkg.sv =====
// shared types and constants of the event log with run-length merging
package elrl_pkg;

    localparam int GROUP_W   = 16;
    localparam int LOCAL_W   = 16;
    localparam int CODE_W    = GROUP_W + LOCAL_W;
    localparam int TIME_W    = 32;
    localparam int RUN_W     = 32;
    localparam int TOTAL_W   = 32;
    localparam int POS_W     = 6;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;

    // command codes on the request channel
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_GROUP = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_LOCAL = 4'd1;

    // reset values of the full marker
    localparam logic [GROUP_W-1:0] FULL_GROUP_RST = 16'd0;
    localparam logic [LOCAL_W-1:0] FULL_LOCAL_RST = 16'd1;

    // classified operation handed from front to back
    typedef enum logic [1:0] {
        OP_NOP   = 2'd0,
        OP_ADD   = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [CODE_W-1:0]   code;
        logic [TIME_W-1:0]   event_time;
        logic [POS_W-1:0]    read_pos;
    } entry_t;

    // head of the front queue as seen by the back
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } q_head_t;

endpackage

// ===== design/elrl_if.sv =====
// request, response and configuration channel interfaces

interface elrl_req_if;
    logic                              valid;
    logic                              ready;
    logic [elrl_pkg::CMD_W-1:0]        cmd;
    logic [elrl_pkg::GROUP_W-1:0]      group_code;
    logic [elrl_pkg::LOCAL_W-1:0]      local_code;
    logic [elrl_pkg::TIME_W-1:0]       event_time;
    logic [elrl_pkg::POS_W-1:0]        read_pos;

    modport source (output valid, cmd, group_code, local_code, event_time, read_pos,
                    input ready);
    modport sink   (input valid, cmd, group_code, local_code, event_time, read_pos,
                    output ready);
endinterface

interface elrl_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              status;
    logic [elrl_pkg::GROUP_W-1:0]      rec_group;
    logic [elrl_pkg::LOCAL_W-1:0]      rec_local;
    logic [elrl_pkg::TIME_W-1:0]       rec_time;
    logic [elrl_pkg::RUN_W-1:0]        rec_run;
    logic [elrl_pkg::TOTAL_W-1:0]      event_total;
    logic [elrl_pkg::POS_W-1:0]        head_pos;

    modport source (output valid, status, rec_group, rec_local, rec_time, rec_run,
                    event_total, head_pos, input ready);
    modport sink   (input valid, status, rec_group, rec_local, rec_time, rec_run,
                    event_total, head_pos, output ready);
endinterface

interface elrl_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [elrl_pkg::CFG_IDX_W-1:0]    index;
    logic [elrl_pkg::CFG_DAT_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/event_log_run_length_merge_core.sv =====
// Event log with run-length merging: top level joining front queue and back end.
// Sustains one request per clock while the response is not stalled: an accepted request
// is stored in the two-entry front queue, issued from it to the back end, and its
// response is held in the response register. The rate is set by the record memory,
// which takes one write (add) or one registered read (read) per cycle;
// the latest record's code and run length sit in registers, so back-to-back adds merge
// without reading the memory. Records are undefined after reset and need no clearing
// pass; configuration writes are taken every cycle.
module event_log_run_length_merge_core #(
    parameter int DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    elrl_req_if.sink    req_ch,
    elrl_rsp_if.source  rsp_ch,
    elrl_cfg_if.sink    cfg_ch
);

    elrl_pkg::q_head_t q_head;
    logic              q_pop;

    // request acceptance and queue
    elrl_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req_ch),
        .q_head (q_head),
        .q_pop  (q_pop)
    );

    // log state and response
    elrl_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_head (q_head),
        .q_pop  (q_pop),
        .cfg    (cfg_ch),
        .rsp    (rsp_ch)
    );

endmodule

// ===== design/elrl_front.sv =====
// front end: accepts requests, classifies them and queues them for the back end
module elrl_front (
    input  logic             clk,
    input  logic             rst_n,
    elrl_req_if.sink         req,
    output elrl_pkg::q_head_t q_head,
    input  logic             q_pop
);

    elrl_pkg::entry_t entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    elrl_pkg::entry_t new_entry;
    elrl_pkg::op_t    op_dec;
    logic             push;

    // command decode
    always_comb
    begin
        unique case (req.cmd)
            elrl_pkg::CMD_ADD:   op_dec = elrl_pkg::OP_ADD;
            elrl_pkg::CMD_READ:  op_dec = elrl_pkg::OP_READ;
            elrl_pkg::CMD_CLEAR: op_dec = elrl_pkg::OP_CLEAR;
            default:             op_dec = elrl_pkg::OP_NOP;
        endcase
    end

    assign new_entry.op         = op_dec;
    assign new_entry.code       = {req.group_code, req.local_code};
    assign new_entry.event_time = req.event_time;
    assign new_entry.read_pos   = req.read_pos;

    // two-entry queue handshake
    assign req.ready = (count_reg != 2'd2);
    assign push      = req.valid && req.ready;

    assign q_head.valid = (count_reg != 2'd0);
    assign q_head.entry = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_entry;
        end
    end

endmodule

// ===== design/elrl_back.sv =====
// back end: record memory, head, event total, run-length merge and response register
module elrl_back #(
    parameter int DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  elrl_pkg::q_head_t q_head,
    output logic              q_pop,
    elrl_cfg_if.sink          cfg,
    elrl_rsp_if.source        rsp
);

    localparam int HW    = $clog2(DEPTH);
    localparam int CW    = (HW > elrl_pkg::POS_W) ? HW : elrl_pkg::POS_W;
    localparam logic [HW-1:0] LAST = HW'(DEPTH - 1);

    typedef struct packed {
        logic [elrl_pkg::CODE_W-1:0] code;
        logic [elrl_pkg::TIME_W-1:0] rtime;
        logic [elrl_pkg::RUN_W-1:0]  run;
    } rec_t;

    rec_t                           mem [DEPTH];
    rec_t                           rd_data_reg;

    logic [HW-1:0]                  head_reg, head_next;
    logic [elrl_pkg::TOTAL_W-1:0]   total_reg, total_next;
    logic [elrl_pkg::CODE_W-1:0]    last_code_reg, last_code_next;
    logic [elrl_pkg::RUN_W-1:0]     last_run_reg, last_run_next;
    logic [elrl_pkg::GROUP_W-1:0]   full_group_reg;
    logic [elrl_pkg::LOCAL_W-1:0]   full_local_reg;

    logic                           out_valid_reg;
    logic                           res_rec_reg;
    logic                           res_status_reg;
    logic [elrl_pkg::TOTAL_W-1:0]   res_total_reg;
    logic [elrl_pkg::POS_W-1:0]     res_head_reg;

    logic                           exec;
    logic                           is_add, is_read, is_clear;
    logic [elrl_pkg::CODE_W-1:0]    add_code;
    logic                           merge;
    logic                           wr_en;
    logic [HW-1:0]                  wr_addr;
    rec_t                           wr_data;
    logic [CW-1:0]                  pos_ext, head_ext, head_out_ext;
    logic                           pos_ok;
    logic                           rd_en;
    logic [HW-1:0]                  rd_addr;

    // configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_group_reg <= elrl_pkg::FULL_GROUP_RST;
            full_local_reg <= elrl_pkg::FULL_LOCAL_RST;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == elrl_pkg::CFG_FULL_GROUP)
            begin
                full_group_reg <= cfg.data;
            end
            if (cfg.index == elrl_pkg::CFG_FULL_LOCAL)
            begin
                full_local_reg <= cfg.data;
            end
        end
    end

    // issue the queued request when the response slot is free or draining
    assign exec     = q_head.valid && (!out_valid_reg || rsp.ready);
    assign q_pop    = exec;
    assign is_add   = exec && (q_head.entry.op == elrl_pkg::OP_ADD);
    assign is_read  = exec && (q_head.entry.op == elrl_pkg::OP_READ);
    assign is_clear = exec && (q_head.entry.op == elrl_pkg::OP_CLEAR);

    // full log substitutes the marker; merge only against a readable latest record
    assign add_code = (head_reg == LAST) ? {full_group_reg, full_local_reg}
                                         : q_head.entry.code;
    assign merge    = (head_reg != '0) && (last_code_reg == add_code);

    // record write
    assign wr_en         = is_add;
    assign wr_addr       = merge ? (head_reg - HW'(1)) : head_reg;
    assign wr_data.code  = add_code;
    assign wr_data.rtime = q_head.entry.event_time;
    assign wr_data.run   = merge ? (last_run_reg + 32'd1) : 32'd1;

    // read range check
    assign pos_ext  = CW'(q_head.entry.read_pos);
    assign head_ext = CW'(head_reg);
    assign pos_ok   = (pos_ext < head_ext);
    assign rd_en    = is_read && pos_ok;
    assign rd_addr  = pos_ext[HW-1:0];

    // head, total and latest record tracking
    always_comb
    begin
        head_next      = head_reg;
        total_next     = total_reg;
        last_code_next = last_code_reg;
        last_run_next  = last_run_reg;
        priority if (is_clear)
        begin
            head_next  = '0;
            total_next = '0;
        end
        else if (is_add)
        begin
            total_next = total_reg + 32'd1;
            if (merge)
            begin
                last_run_next = last_run_reg + 32'd1;
            end
            else if (head_reg != LAST)
            begin
                head_next      = head_reg + HW'(1);
                last_code_next = add_code;
                last_run_next  = 32'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            total_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_code_reg <= last_code_next;
        last_run_reg  <= last_run_next;
    end

    // record memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // response register
    assign head_out_ext = CW'(head_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (exec)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            res_rec_reg    <= rd_en;
            res_status_reg <= is_read && !pos_ok;
            res_total_reg  <= total_next;
            res_head_reg   <= head_out_ext[elrl_pkg::POS_W-1:0];
        end
    end

    // response payload
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = res_status_reg;
    assign rsp.rec_group   = res_rec_reg ? rd_data_reg.code[elrl_pkg::CODE_W-1:elrl_pkg::LOCAL_W]
                                         : '0;
    assign rsp.rec_local   = res_rec_reg ? rd_data_reg.code[elrl_pkg::LOCAL_W-1:0] : '0;
    assign rsp.rec_time    = res_rec_reg ? rd_data_reg.rtime : '0;
    assign rsp.rec_run     = res_rec_reg ? rd_data_reg.run : '0;
    assign rsp.event_total = res_total_reg;
    assign rsp.head_pos    = res_head_reg;

    // clear empties the log and the event count
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        is_clear |=> (head_reg == '0) && (total_reg == '0))
        else $error("clear did not reset head and total");

    // every add counts exactly once
    a_total: assert property (@(posedge clk) disable iff (!rst_n)
        is_add |=> total_reg == $past(total_reg) + 32'd1)
        else $error("event total not advanced by add");

    // an append below the last slot moves the head by one
    a_append: assert property (@(posedge clk) disable iff (!rst_n)
        (is_add && !merge && (head_reg != LAST)) |=> head_reg == $past(head_reg) + HW'(1))
        else $error("append did not advance head");

    // head never passes the last slot
    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= LAST)
        else $error("head beyond last slot");

    // a failed read never carries record data
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_status_reg) |-> !res_rec_reg)
        else $error("out-of-range read shows a record");

endmodule
